@@ hdl/jsu_pkg.sv @@
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_NORMAL     = 3'd1,
        MODE_ESCAPE     = 3'd2,
        MODE_HEX_FIRST  = 3'd3,
        MODE_WANT_BSL   = 3'd4,
        MODE_WANT_U     = 3'd5,
        MODE_HEX_SECOND = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_MISSING_QUOTE = 3'd1,
        ERR_CONTROL       = 3'd2,
        ERR_ESCAPE        = 3'd3,
        ERR_HEX           = 3'd4,
        ERR_SURROGATE     = 3'd5
    } t_err;

    // characters with a meaning in a string body
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_string;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        t_err       error_code;
        logic       last;
    } t_out_req;

    // all results caused by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        t_kind           kind;
        t_err            code;
    } t_grp;

endpackage

@@ hdl/jsu_decode.sv @@
module jsu_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  jsu_pkg::t_in_req i_req,
    output logic            o_grp_valid,
    output jsu_pkg::t_grp   o_grp
);
    import jsu_pkg::*;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_hs, n_hs;

    t_mode       mode_eff;
    logic [1:0]  hcnt_eff;
    logic [15:0] acc_eff;
    logic [9:0]  hs_eff;
    logic [7:0]  c;
    logic        dig_ok;
    logic [3:0]  dig;
    logic [15:0] acc_new;
    logic        hex_done;
    logic        is_high;
    logic        is_low;
    logic [20:0] cp;
    logic [7:0]  esc_val;
    logic        esc_ok;

    assign c        = i_req.in_byte;
    assign mode_eff = i_req.start_string ? MODE_NORMAL : r_mode;
    assign hcnt_eff = i_req.start_string ? 2'd0 : r_hcnt;
    assign acc_eff  = i_req.start_string ? 16'd0 : r_acc;
    assign hs_eff   = i_req.start_string ? 10'd0 : r_hs;

    always_comb begin
        dig_ok = 1'b1;
        dig    = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            dig = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            dig = c[3:0] + 4'd9;
        end else begin
            dig_ok = 1'b0;
        end
    end

    always_comb begin
        esc_ok  = 1'b1;
        esc_val = c;
        case (c) inside
            CH_QUOTE, CH_BSL, CH_SLASH: esc_val = c;
            CH_B:                       esc_val = 8'h08;
            CH_F:                       esc_val = 8'h0C;
            CH_N:                       esc_val = 8'h0A;
            CH_T:                       esc_val = 8'h09;
            CH_R:                       esc_val = 8'h0D;
            default:                    esc_ok  = 1'b0;
        endcase
    end

    assign acc_new  = {acc_eff[11:0], dig};
    assign hex_done = (hcnt_eff == 2'd3);
    assign is_high  = (acc_new >= 16'hD800) && (acc_new <= 16'hDBFF);
    assign is_low   = (acc_new >= 16'hDC00) && (acc_new <= 16'hDFFF);
    assign cp = (mode_eff == MODE_HEX_SECOND) ?
                (21'h10000 + {1'b0, hs_eff, acc_new[9:0]}) : {5'd0, acc_new};

    // next state
    always_comb begin
        n_mode = mode_eff;
        n_hcnt = hcnt_eff;
        n_acc  = acc_eff;
        n_hs   = hs_eff;
        unique case (mode_eff) inside
            MODE_NORMAL: begin
                if (c == CH_QUOTE || c < 8'h20) begin
                    n_mode = MODE_IDLE;
                end else if (c == CH_BSL) begin
                    n_mode = MODE_ESCAPE;
                end
            end
            MODE_ESCAPE: begin
                if (c == CH_U) begin
                    n_mode = MODE_HEX_FIRST;
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                end else if (esc_ok) begin
                    n_mode = MODE_NORMAL;
                end else begin
                    n_mode = MODE_IDLE;
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                    n_hs   = 10'd0;
                end
            end
            MODE_HEX_FIRST, MODE_HEX_SECOND: begin
                if (!dig_ok || (hex_done && mode_eff == MODE_HEX_SECOND && !is_low)) begin
                    n_mode = MODE_IDLE;
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                    n_hs   = 10'd0;
                end else if (!hex_done) begin
                    n_hcnt = hcnt_eff + 2'd1;
                    n_acc  = acc_new;
                end else if (mode_eff == MODE_HEX_FIRST && is_high) begin
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                    n_hs   = acc_new[9:0];
                    n_mode = MODE_WANT_BSL;
                end else begin
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                    n_hs   = 10'd0;
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_WANT_BSL: begin
                if (c == CH_BSL) begin
                    n_mode = MODE_WANT_U;
                end else begin
                    n_mode = MODE_IDLE;
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                    n_hs   = 10'd0;
                end
            end
            MODE_WANT_U: begin
                if (c == CH_U) begin
                    n_mode = MODE_HEX_SECOND;
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                end else begin
                    n_mode = MODE_IDLE;
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                    n_hs   = 10'd0;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                n_hcnt = 2'd0;
                n_acc  = 16'd0;
                n_hs   = 10'd0;
            end
        endcase
    end

    // result group
    always_comb begin
        o_grp_valid     = 1'b0;
        o_grp.bytes     = '0;
        o_grp.last_idx  = 2'd0;
        o_grp.kind      = KIND_DATA;
        o_grp.code      = ERR_NONE;
        unique case (mode_eff) inside
            MODE_NORMAL: begin
                if (c == CH_QUOTE) begin
                    o_grp_valid = 1'b1;
                    o_grp.kind  = KIND_END;
                end else if (c == 8'h00) begin
                    o_grp_valid = 1'b1;
                    o_grp.kind  = KIND_ERROR;
                    o_grp.code  = ERR_MISSING_QUOTE;
                end else if (c < 8'h20) begin
                    o_grp_valid = 1'b1;
                    o_grp.kind  = KIND_ERROR;
                    o_grp.code  = ERR_CONTROL;
                end else if (c != CH_BSL) begin
                    o_grp_valid    = 1'b1;
                    o_grp.bytes[0] = c;
                end
            end
            MODE_ESCAPE: begin
                if (c != CH_U) begin
                    o_grp_valid = 1'b1;
                    if (esc_ok) begin
                        o_grp.bytes[0] = esc_val;
                    end else begin
                        o_grp.kind = KIND_ERROR;
                        o_grp.code = ERR_ESCAPE;
                    end
                end
            end
            MODE_HEX_FIRST, MODE_HEX_SECOND: begin
                if (!dig_ok) begin
                    o_grp_valid = 1'b1;
                    o_grp.kind  = KIND_ERROR;
                    o_grp.code  = ERR_HEX;
                end else if (hex_done) begin
                    if (mode_eff == MODE_HEX_SECOND && !is_low) begin
                        o_grp_valid = 1'b1;
                        o_grp.kind  = KIND_ERROR;
                        o_grp.code  = ERR_SURROGATE;
                    end else if (!(mode_eff == MODE_HEX_FIRST && is_high)) begin
                        o_grp_valid = 1'b1;
                        if (cp <= 21'h7F) begin
                            o_grp.bytes[0] = cp[7:0];
                        end else if (cp <= 21'h7FF) begin
                            o_grp.bytes[0] = {3'b110, cp[10:6]};
                            o_grp.bytes[1] = {2'b10, cp[5:0]};
                            o_grp.last_idx = 2'd1;
                        end else if (cp <= 21'hFFFF) begin
                            o_grp.bytes[0] = {4'b1110, cp[15:12]};
                            o_grp.bytes[1] = {2'b10, cp[11:6]};
                            o_grp.bytes[2] = {2'b10, cp[5:0]};
                            o_grp.last_idx = 2'd2;
                        end else begin
                            o_grp.bytes[0] = {5'b11110, cp[20:18]};
                            o_grp.bytes[1] = {2'b10, cp[17:12]};
                            o_grp.bytes[2] = {2'b10, cp[11:6]};
                            o_grp.bytes[3] = {2'b10, cp[5:0]};
                            o_grp.last_idx = 2'd3;
                        end
                    end
                end
            end
            MODE_WANT_BSL: begin
                if (c != CH_BSL) begin
                    o_grp_valid = 1'b1;
                    o_grp.kind  = KIND_ERROR;
                    o_grp.code  = ERR_SURROGATE;
                end
            end
            MODE_WANT_U: begin
                if (c != CH_U) begin
                    o_grp_valid = 1'b1;
                    o_grp.kind  = KIND_ERROR;
                    o_grp.code  = ERR_SURROGATE;
                end
            end
            default: begin
                o_grp_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_hcnt <= 2'd0;
            r_acc  <= 16'd0;
            r_hs   <= 10'd0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_hcnt <= n_hcnt;
            r_acc  <= n_acc;
            r_hs   <= n_hs;
        end
    end

endmodule

@@ hdl/jsu_serial.sv @@
module jsu_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  jsu_pkg::t_grp     i_grp,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output jsu_pkg::t_out_req o_out_req
);
    import jsu_pkg::*;

    logic       r_valid;
    t_grp       r_grp;
    logic [1:0] r_idx;
    logic       take;
    logic       done;

    assign take    = r_valid && !i_out_stall;
    assign done    = take && (r_idx == r_grp.last_idx);
    assign o_ready = !r_valid || done;

    assign o_out_valid          = r_valid;
    assign o_out_req.out_byte   = r_grp.bytes[r_idx];
    assign o_out_req.kind       = r_grp.kind;
    assign o_out_req.error_code = r_grp.code;
    assign o_out_req.last       = (r_idx == r_grp.last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

endmodule

@@ hdl/json_string_unescape_utf8.sv @@
// JSON string body unescaper with UTF-8 output.
// Input channel: i_in_valid / o_in_stall carry one text byte per request, with
// start_string set on the first byte after the opening quote.
// Output channel: o_out_valid / i_out_stall carry one result per request: a data
// byte, a string end or an error; last marks the final result of an input byte.
// The first result of a byte is offered in the cycle after the byte is taken.
// Throughput, unstalled: one byte per cycle while each gives at most one result;
// a byte that ends a \u escape gives up to four UTF-8 bytes, sent one per cycle,
// and input is stalled until the last of them is taken. The output buffer holds
// one result group, so a new byte is taken in the same cycle the old group ends.
// Reset: input stalled, scanner idle, output empty; bytes arriving before a
// start are dropped.
// Stall on the output freezes the offered result and, once the group buffer
// is full, raises o_in_stall.
module json_string_unescape_utf8 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  jsu_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output jsu_pkg::t_out_req o_out_req
);
    import jsu_pkg::*;

    logic take;
    logic ready;
    logic grp_valid;
    t_grp grp;

    assign o_in_stall = !ready || !i_rst_n;
    assign take       = i_in_valid && !o_in_stall;

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_req       (i_in_req),
        .o_grp_valid (grp_valid),
        .o_grp       (grp)
    );

    jsu_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take && grp_valid),
        .i_grp       (grp),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule
